// ===== rtl/core/bpjs_pkg.sv =====
// bpjs_pkg: shared types, codes and constants of the job scheduler
// used by bpjs_ctrl, bpjs_dpath and budgeted_priority_job_scheduler
`default_nettype none
package bpjs_pkg;
	localparam int unsigned DefQueueDepth = 16;
	localparam logic [39:0] BudgetReset = 40'd1073741824;

	typedef enum logic [2:0] {
		ACT_SUBMIT   = 3'd0,
		ACT_DISPATCH = 3'd1,
		ACT_COMPLETE = 3'd2,
		ACT_SETGEN   = 3'd3,
		ACT_SHUTDOWN = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_REJECTED = 3'd1,
		ST_DISPATCH = 3'd2,
		ST_NONE     = 3'd3,
		ST_DELIVER  = 3'd4,
		ST_DROPPED  = 3'd5,
		ST_GENSET   = 3'd6,
		ST_SHUTDOWN = 3'd7
	} status_t;

	localparam logic [1:0] RegBudget = 2'd0;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] job_id;
		logic [31:0] generation;
		logic [1:0]  priority_req;
		logic [39:0] reservation;
		logic        cancelled;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_job_id;
		logic [31:0] out_generation;
		logic [39:0] out_reservation;
		logic [4:0]  waiting_jobs;
		logic [39:0] running_bytes;
		logic [4:0]  purged_count;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // latch input item, clear scan state
		logic scan;   // examine slot at scan index
		logic finish; // commit the operation, build result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/bpjs_ctrl.sv =====
// bpjs_ctrl: sequencer for the scheduler, one slot per scan cycle
// depends on bpjs_pkg; drives bpjs_dpath through cmd_t
`default_nettype none
module bpjs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_fire,
	input  wire logic           out_fire,
	input  wire bpjs_pkg::stat_t stat,
	output bpjs_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                out_valid
);
	import bpjs_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_OUT} state_t;
	state_t state_q;

	always_comb begin
		cmd.load = in_fire;
		cmd.scan = (state_q == S_SCAN);
		cmd.finish = (state_q == S_FIN);
	end

	// a new item may enter in the cycle the held result is taken
	assign busy = (state_q == S_SCAN) || (state_q == S_FIN) ||
		((state_q == S_OUT) && !out_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_fire) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_SCAN;
				S_SCAN: if (stat.scan_last) state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: begin
					if (out_fire) state_q <= in_fire ? S_SCAN : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/bpjs_dpath.sv =====
// bpjs_dpath: slot table, scan registers and result register
// depends on bpjs_pkg; steered by bpjs_ctrl
`default_nettype none
module bpjs_dpath #(
	parameter int unsigned QUEUE_DEPTH = bpjs_pkg::DefQueueDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bpjs_pkg::cmd_t   cmd,
	input  wire bpjs_pkg::item_t  item,
	input  wire logic [39:0]      budget,
	output bpjs_pkg::stat_t       stat,
	output bpjs_pkg::result_t     result
);
	import bpjs_pkg::*;

	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [31:0] id_mem [QUEUE_DEPTH];
	logic [31:0] gen_mem [QUEUE_DEPTH];
	logic [1:0]  pri_mem [QUEUE_DEPTH];
	logic [39:0] res_mem [QUEUE_DEPTH];
	logic [31:0] arr_mem [QUEUE_DEPTH];

	item_t       it_q;
	logic [IW-1:0] idx_q;
	logic        found_q;
	logic [IW-1:0] best_q;
	logic [1:0]  best_pri_q;
	logic [31:0] best_age_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] purge_q;
	logic [39:0] run_q;
	logic [31:0] cur_gen_q;
	logic [31:0] arr_cnt_q;
	logic        shut_q;

	assign stat.scan_last = (idx_q == IW'(QUEUE_DEPTH - 1));

	logic [1:0] pri_sat;
	assign pri_sat = (item.priority_req == 2'd3) ? 2'd2 : item.priority_req;

	logic [40:0] fit_sum;
	logic [31:0] age;
	logic        cand;
	always_comb begin
		fit_sum = {1'b0, res_mem[idx_q]} + {1'b0, run_q};
		age = arr_cnt_q - arr_mem[idx_q];
		cand = valid_q[idx_q] && (fit_sum <= {1'b0, budget}) &&
			(!found_q || (pri_mem[idx_q] > best_pri_q) ||
			 ((pri_mem[idx_q] == best_pri_q) && (age > best_age_q)));
	end

	logic sub_ok, disp_ok;
	assign sub_ok = !shut_q && (it_q.reservation <= budget) && found_q;
	assign disp_ok = found_q;

	always_ff @(posedge clk) begin
		if (cmd.load) it_q <= '{item.action, item.job_id, item.generation,
			pri_sat, item.reservation, item.cancelled};
		if (cmd.finish && it_q.action == ACT_SUBMIT && sub_ok) begin
			id_mem[best_q] <= it_q.job_id;
			gen_mem[best_q] <= it_q.generation;
			pri_mem[best_q] <= it_q.priority_req;
			res_mem[best_q] <= it_q.reservation;
			arr_mem[best_q] <= arr_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_pri_q <= '0;
			best_age_q <= '0;
			cnt_q <= '0;
			purge_q <= '0;
			run_q <= '0;
			cur_gen_q <= '0;
			arr_cnt_q <= '0;
			shut_q <= 1'b0;
			result <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
			found_q <= 1'b0;
			purge_q <= '0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			case (it_q.action)
				ACT_SUBMIT: begin
					if (!valid_q[idx_q] && !found_q) begin
						found_q <= 1'b1;
						best_q <= idx_q;
					end
				end
				ACT_DISPATCH: begin
					if (cand) begin
						found_q <= 1'b1;
						best_q <= idx_q;
						best_pri_q <= pri_mem[idx_q];
						best_age_q <= age;
					end
				end
				ACT_SETGEN: begin
					if (valid_q[idx_q] && gen_mem[idx_q] < it_q.generation) begin
						valid_q[idx_q] <= 1'b0;
						purge_q <= purge_q + 1'b1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ACT_SHUTDOWN: begin
					if (!shut_q && valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b0;
						purge_q <= purge_q + 1'b1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: ;
			endcase
		end else if (cmd.finish) begin
			result <= '0;
			result.waiting_jobs <= 5'(cnt_q);
			result.running_bytes <= run_q;
			result.status <= ST_REJECTED;
			case (it_q.action)
				ACT_SUBMIT: begin
					if (sub_ok) begin
						valid_q[best_q] <= 1'b1;
						arr_cnt_q <= arr_cnt_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
						result.waiting_jobs <= 5'(cnt_q + 1'b1);
						result.status <= ST_ACCEPTED;
					end
				end
				ACT_DISPATCH: begin
					if (disp_ok) begin
						valid_q[best_q] <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
						run_q <= run_q + res_mem[best_q];
						result.waiting_jobs <= 5'(cnt_q - 1'b1);
						result.running_bytes <= run_q + res_mem[best_q];
						result.status <= ST_DISPATCH;
						result.out_job_id <= id_mem[best_q];
						result.out_generation <= gen_mem[best_q];
						result.out_reservation <= res_mem[best_q];
					end else begin
						result.status <= ST_NONE;
					end
				end
				ACT_COMPLETE: begin
					run_q <= (it_q.reservation > run_q) ? '0 : run_q - it_q.reservation;
					result.running_bytes <= (it_q.reservation > run_q) ? '0 :
						run_q - it_q.reservation;
					result.status <= (!shut_q && !it_q.cancelled &&
						it_q.generation == cur_gen_q) ? ST_DELIVER : ST_DROPPED;
					result.out_job_id <= it_q.job_id;
					result.out_generation <= it_q.generation;
				end
				ACT_SETGEN: begin
					cur_gen_q <= it_q.generation;
					result.status <= ST_GENSET;
					result.purged_count <= 5'(purge_q);
				end
				ACT_SHUTDOWN: begin
					shut_q <= 1'b1;
					result.status <= ST_SHUTDOWN;
					result.purged_count <= 5'(purge_q);
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/budgeted_priority_job_scheduler.sv =====
// budgeted_priority_job_scheduler: top level, stream ports and apb register
// depends on bpjs_pkg, bpjs_ctrl and bpjs_dpath
//
// channel  direction  width  content
// s_axis   in         112    action, job_id, generation, priority_req, reservation, cancelled
// m_axis   out        160    status .. purged_count
// apb      in/out     64     byte_budget[39:0] at address 0
//
// every transaction scans the table one slot per scan cycle, then commits
// the operation in the finish state before its result is offered on m_axis.
// s_axis_tready is low while a result waits on m_axis; the next item is taken
// in the cycle that result is accepted.
// reset is asynchronous; the table comes up empty without a clearing pass.
`default_nettype none
module budgeted_priority_job_scheduler #(
	parameter int unsigned QUEUE_DEPTH = bpjs_pkg::DefQueueDepth
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// action[2:0], job_id[34:3], generation[66:35], priority_req[68:67],
	// reservation[108:69], cancelled[109], zero fill
	input  wire logic [111:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status[2:0], out_job_id[34:3], out_generation[66:35],
	// out_reservation[106:67], waiting_jobs[111:107], running_bytes[151:112],
	// purged_count[156:152], zero fill
	output logic [159:0]      m_axis_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [1:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import bpjs_pkg::*;

	logic [39:0] budget_q;
	logic busy, in_fire, out_fire;
	cmd_t cmd;
	stat_t stat;
	item_t item;
	result_t res;

	assign pready = 1'b1;
	assign prdata = (paddr == RegBudget) ? {24'd0, budget_q} : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) budget_q <= BudgetReset;
		else if (psel && penable && pwrite && paddr == RegBudget) budget_q <= pwdata[39:0];
	end

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	assign item = '{s_axis_tdata[2:0], s_axis_tdata[34:3], s_axis_tdata[66:35],
		s_axis_tdata[68:67], s_axis_tdata[108:69], s_axis_tdata[109]};

	assign m_axis_tdata = {3'd0, res.purged_count, res.running_bytes, res.waiting_jobs,
		res.out_reservation, res.out_generation, res.out_job_id, res.status};

	bpjs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
	);

	bpjs_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(item), .budget(budget_q),
		.stat(stat), .result(res)
	);
endmodule
`default_nettype wire

// ===== tb/sv/tb_budgeted_priority_job_scheduler.sv =====
// tb_budgeted_priority_job_scheduler: self-checking bench for the job scheduler
// drives submit/dispatch/complete/generation/shutdown transactions, checks every result
// depends on bpjs_pkg and budgeted_priority_job_scheduler
`timescale 1ns / 1ps
`default_nettype none
module tb_budgeted_priority_job_scheduler;
	import bpjs_pkg::*;

	localparam int Depth = 16;
	localparam int SchedLatency = Depth + 2;
	localparam logic [2:0] ActUnknown = 3'd5;
	localparam logic [2:0] ActUnknownTop = 3'd7;
	localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;
	localparam int CycleLimit = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [111:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [159:0] m_axis_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	always #6 clk = ~clk;

	budgeted_priority_job_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// scheduler shadow state
	logic        sh_valid [Depth];
	logic [31:0] sh_id    [Depth];
	logic [31:0] sh_gen   [Depth];
	logic [1:0]  sh_prio  [Depth];
	logic [39:0] sh_res   [Depth];
	logic [31:0] sh_arr   [Depth];
	logic [39:0] sh_running;
	logic [31:0] sh_cur_gen;
	logic [31:0] sh_arrival;
	logic        sh_down;
	logic [39:0] sh_budget;

	result_t expected_results[$];
	logic [39:0] running_res[$];
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_dispatched = 0;
	int n_rejected = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_tog = 1'b0;
	logic hold_seen = 1'b0;
	int hold_cnt = 0;
	int cycles = 0;

	function automatic result_t schedule_step(item_t it);
		result_t r;
		logic [1:0] p;
		int best;
		logic [31:0] best_age, age;
		logic [40:0] sum;
		int q;
		r = '0;
		r.status = ST_REJECTED;
		p = (it.priority_req > 2'd2) ? 2'd2 : it.priority_req;
		case (it.action)
			ACT_SUBMIT: begin
				if (!sh_down && it.reservation <= sh_budget)
					for (int i = 0; i < Depth; i++)
						if (!sh_valid[i]) begin
							sh_valid[i] = 1'b1;
							sh_id[i] = it.job_id;
							sh_gen[i] = it.generation;
							sh_prio[i] = p;
							sh_res[i] = it.reservation;
							sh_arr[i] = sh_arrival;
							sh_arrival = sh_arrival + 32'd1;
							r.status = ST_ACCEPTED;
							break;
						end
			end
			ACT_DISPATCH: begin
				best = -1;
				best_age = '0;
				for (int i = 0; i < Depth; i++) begin
					sum = {1'b0, sh_res[i]} + {1'b0, sh_running};
					age = sh_arrival - sh_arr[i];
					if (sh_valid[i] && sum <= {1'b0, sh_budget} &&
						(best < 0 || sh_prio[i] > sh_prio[best] ||
						(sh_prio[i] == sh_prio[best] && age > best_age))) begin
						best = i;
						best_age = age;
					end
				end
				if (best < 0) begin
					r.status = ST_NONE;
				end else begin
					sh_valid[best] = 1'b0;
					sh_running = sh_running + sh_res[best];
					r.status = ST_DISPATCH;
					r.out_job_id = sh_id[best];
					r.out_generation = sh_gen[best];
					r.out_reservation = sh_res[best];
				end
			end
			ACT_COMPLETE: begin
				sh_running = (it.reservation > sh_running) ? '0 : sh_running - it.reservation;
				r.status = (!sh_down && !it.cancelled && it.generation == sh_cur_gen) ?
					ST_DELIVER : ST_DROPPED;
				r.out_job_id = it.job_id;
				r.out_generation = it.generation;
			end
			ACT_SETGEN: begin
				sh_cur_gen = it.generation;
				for (int i = 0; i < Depth; i++)
					if (sh_valid[i] && sh_gen[i] < it.generation) begin
						sh_valid[i] = 1'b0;
						r.purged_count++;
					end
				r.status = ST_GENSET;
			end
			ACT_SHUTDOWN: begin
				if (!sh_down) begin
					sh_down = 1'b1;
					for (int i = 0; i < Depth; i++)
						if (sh_valid[i]) begin
							sh_valid[i] = 1'b0;
							r.purged_count++;
						end
				end
				r.status = ST_SHUTDOWN;
			end
			default: ;
		endcase
		q = 0;
		for (int i = 0; i < Depth; i++)
			if (sh_valid[i])
				q++;
		r.waiting_jobs = q[4:0];
		r.running_bytes = sh_running;
		return r;
	endfunction

	task automatic send_item(item_t it, bit has_typed, result_t typed);
		result_t r;
		s_axis_tdata <= {2'b0, it.cancelled, it.reservation, it.priority_req,
			it.generation, it.job_id, it.action};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = schedule_step(it);
		expected_results.push_back(has_typed ? typed : r);
		if (r.status == ST_DISPATCH) begin
			running_res.push_back(r.out_reservation);
			n_dispatched++;
		end
		if (r.status == ST_REJECTED)
			n_rejected++;
		n_items++;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SchedLatency + 4) @(posedge clk);
	endtask

	task automatic write_budget(logic [39:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= RegBudget;
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sh_budget = v;
		@(posedge clk);
	endtask

	function automatic item_t mk(logic [2:0] a, logic [31:0] id, logic [31:0] g,
		logic [1:0] p, logic [39:0] res, logic c);
		item_t it;
		it.action = a;
		it.job_id = id;
		it.generation = g;
		it.priority_req = p;
		it.reservation = res;
		it.cancelled = c;
		return it;
	endfunction

	function automatic logic [39:0] pick_reservation();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 11))
			0: return '0;
			1: return sh_budget;
			2: return sh_budget + 40'd1;
			3: return w[39:0];
			4: return Max40;
			default: return 40'(w % ({24'd0, sh_budget} / 4 + 1));
		endcase
	endfunction

	function automatic item_t random_item(bit submit_heavy);
		item_t it;
		int k;
		logic [63:0] w;
		it.job_id = $urandom;
		it.generation = ($urandom_range(0, 19) == 0) ? $urandom : sh_cur_gen + $urandom_range(0, 3);
		it.priority_req = 2'($urandom_range(0, 3));
		it.cancelled = ($urandom_range(0, 4) == 0);
		it.reservation = pick_reservation();
		k = $urandom_range(0, 99);
		if (submit_heavy)
			k = k / 2;
		if (k < 40) begin
			it.action = ACT_SUBMIT;
		end else if (k < 70) begin
			it.action = ACT_DISPATCH;
		end else if (k < 88) begin
			it.action = ACT_COMPLETE;
			if (running_res.size() != 0 && $urandom_range(0, 9) < 8)
				it.reservation = running_res.pop_front();
			if ($urandom_range(0, 2) != 0)
				it.generation = sh_cur_gen;
		end else if (k < 97) begin
			it.action = ACT_SETGEN;
			w = {$urandom, $urandom};
			it.generation = ($urandom_range(0, 9) == 0) ? w[31:0] : sh_cur_gen + $urandom_range(0, 2);
		end else begin
			it.action = 3'($urandom_range(ActUnknown, ActUnknownTop));
		end
		return it;
	endfunction

	task automatic random_run(int n);
		for (int i = 0; i < n; i++)
			send_item(random_item(1'b0), 1'b0, '0);
	endtask

	// result side: random back-pressure and a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_cnt <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{status: m_axis_tdata[2:0], out_job_id: m_axis_tdata[34:3],
				out_generation: m_axis_tdata[66:35], out_reservation: m_axis_tdata[106:67],
				waiting_jobs: m_axis_tdata[111:107], running_bytes: m_axis_tdata[151:112],
				purged_count: m_axis_tdata[156:152]};
			n_results++;
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing expected: %h", got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("out_job_id", want.out_job_id, got.out_job_id);
				check_field("out_generation", want.out_generation, got.out_generation);
				check_field("out_reservation", want.out_reservation, got.out_reservation);
				check_field("waiting_jobs", want.waiting_jobs, got.waiting_jobs);
				check_field("running_bytes", want.running_bytes, got.running_bytes);
				check_field("purged_count", want.purged_count, got.purged_count);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_budgeted_priority_job_scheduler: errors");
			$finish;
		end
	end

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} stim_row_t;

	initial begin
		stim_row_t rows[$];
		result_t t;
		for (int i = 0; i < Depth; i++)
			sh_valid[i] = 1'b0;
		sh_running = '0;
		sh_cur_gen = '0;
		sh_arrival = '0;
		sh_down = 1'b0;
		sh_budget = BudgetReset;

		// typed rows hold right after reset: empty table, zero running total
		t = '0; t.status = ST_NONE;
		rows.push_back('{mk(ACT_DISPATCH, 0, 0, 0, 0, 0), 1'b1, t});
		t = '0; t.status = ST_REJECTED;
		rows.push_back('{mk(ActUnknown, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, Max40, 1), 1'b1, t});
		rows.push_back('{mk(ACT_SUBMIT, 32'hFFFF_FFFF, 0, 3, BudgetReset + 40'd1, 0), 1'b1, t});
		t = '0; t.status = ST_DELIVER; t.out_job_id = 32'hFFFF_FFFF;
		rows.push_back('{mk(ACT_COMPLETE, 32'hFFFF_FFFF, 0, 0, Max40, 0), 1'b1, t});
		t = '0; t.status = ST_DROPPED; t.out_job_id = 32'h1;
		rows.push_back('{mk(ACT_COMPLETE, 32'h1, 0, 0, 0, 1), 1'b1, t});
		t = '0; t.status = ST_DROPPED; t.out_generation = 32'hFFFF_FFFF;
		rows.push_back('{mk(ACT_COMPLETE, 0, 32'hFFFF_FFFF, 0, 0, 0), 1'b1, t});
		// predicted rows: priorities, saturation, age order, fit test, purge
		rows.push_back('{mk(ACT_SUBMIT, 32'h10, 5, 0, BudgetReset, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_SUBMIT, 32'h11, 5, 3, 40'd100, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_SUBMIT, 32'h12, 5, 2, 40'd200, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_SUBMIT, 32'h13, 5, 1, 40'd0, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_SUBMIT, 32'h14, 2, 1, 40'd1, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_SETGEN, 0, 5, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_COMPLETE, 32'h11, 5, 0, 40'd300, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_SETGEN, 0, 32'hFFFF_FFFF, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(ACT_SETGEN, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(ActUnknownTop, 0, 0, 2, 0, 0), 1'b0, '0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_item(rows[i].it, rows[i].typed, rows[i].res);
		drain_results();

		// reset budget; long result hold-off while a submit-heavy burst fills the table
		tx_idle_pct = 37;
		rx_idle_pct = 67;
		hold_tog <= ~hold_tog;
		for (int i = 0; i < 40; i++)
			send_item(random_item(1'b1), 1'b0, '0);
		random_run(360);
		drain_results();

		write_budget(Max40);
		tx_idle_pct = 67;
		rx_idle_pct = 37;
		random_run(220);
		drain_results();
		random_run(230);
		drain_results();

		write_budget('0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_run(150);
		drain_results();

		write_budget(40'd5000);
		random_run(400);
		drain_results();

		write_budget({8'($urandom_range(0, 255)), 32'($urandom)});
		random_run(350);
		drain_results();

		// shutdown with jobs queued, repeated shutdown, then traffic after shutdown
		for (int i = 0; i < 6; i++)
			send_item(mk(ACT_SUBMIT, $urandom, sh_cur_gen, 1, 0, 0), 1'b0, '0);
		send_item(mk(ACT_SHUTDOWN, 0, 0, 0, 0, 0), 1'b0, '0);
		send_item(mk(ACT_SHUTDOWN, 0, 0, 0, 0, 0), 1'b0, '0);
		random_run(50);
		drain_results();

		$display("%0d transactions in, %0d results checked, %0d dispatched, %0d rejected",
			n_items, n_results, n_dispatched, n_rejected);
		$display("budgets covered: reset value, max, zero, small and random; shutdown at end");
		if (errors == 0) begin
			$display("tb_budgeted_priority_job_scheduler: clean");
		end else begin
			$display("tb_budgeted_priority_job_scheduler: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
